// ----- design/trb_pkg.sv -----
// Shared constants and widths for the trigger readout buffer.
package trb_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int PACKET_TICKS = 40;
	localparam int TAG_WIDTH = 32;

	localparam int TAG_W = 32;
	localparam int OCC_W = 6;
	localparam int BUSY_W = 32;

	// Stored tags never carry more than the port width.
	localparam int STORE_W = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int XING_W = $clog2(PACKET_TICKS + 2);

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef logic [STORE_W-1:0] tag_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [XING_W-1:0] xing_t;

endpackage

// ----- design/trb_if.sv -----
// Tick and result channel interfaces of the trigger readout buffer.
interface trb_tick_if import trb_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic trigger;
	logic [TAG_W-1:0] event_tag;

	modport source (output valid, output cmd, output trigger, output event_tag, input ready);
	modport sink (input valid, input cmd, input trigger, input event_tag, output ready);
endinterface

interface trb_result_if import trb_pkg::*; ();
	logic valid;
	logic ready;
	logic event_done;
	logic [TAG_W-1:0] done_tag;
	logic [OCC_W-1:0] occupancy;
	logic buffer_full;
	logic [BUSY_W-1:0] busy_ticks;
	logic trigger_dropped;

	modport source (output valid, output event_done, output done_tag, output occupancy,
		output buffer_full, output busy_ticks, output trigger_dropped, input ready);
	modport sink (input valid, input event_done, input done_tag, input occupancy,
		input buffer_full, input busy_ticks, input trigger_dropped, output ready);
endinterface

// ----- design/trigger_readout_buffer_top.sv -----
// Top level of the trigger readout buffer (trigger derandomizer).
//
// The tick channel carries one transaction per bunch crossing: cmd selects a
// normal tick or a clear, trigger marks a level-one accept and event_tag is
// the tag queued with it. Every tick transaction yields exactly one result
// transaction with the done flag, the finished tag, the occupancy, the full
// flag, the busy tick count and the drop flag for that tick.
//
// Tags sit in a row of cells with the oldest at the front; a pop shifts the
// whole row by one cell. Each tick's result is registered and appears in the
// output register on the next cycle, so the block takes one tick per cycle
// as long as the result side keeps up.
// The tick channel stays ready while the output register is empty or is
// being taken in the same cycle; when the receiver stalls, ready drops and
// the held result stays unchanged.
//
// Reset empties the queue and clears all counters and the output valid flag.
// Tag cells are not reset; only cells holding a queued tag are ever read.
module trigger_readout_buffer_top import trb_pkg::*; (
	input logic clk,
	input logic arst_n,
	trb_tick_if.sink tick,
	trb_result_if.source result
);

	localparam xing_t XingDone = XING_W'(PACKET_TICKS);
	localparam cnt_t CntDepth = CNT_W'(BUFFER_DEPTH);

	cnt_t count_q;
	xing_t xing_q;
	logic done_q;
	logic [BUSY_W-1:0] busy_q;

	logic out_valid_q;
	logic out_done_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [OCC_W-1:0] out_occ_q;
	logic out_full_q;
	logic [BUSY_W-1:0] out_busy_q;
	logic out_drop_q;

	tag_t cell_tag [BUFFER_DEPTH];
	tag_t tag_in;

	logic fire;
	logic clear;
	logic push;
	logic pop;
	logic drop;
	cnt_t cnt_pushed;
	cnt_t wr_pos;
	xing_t xing_inc;
	cnt_t count_d;
	xing_t xing_d;
	logic done_d;
	logic [BUSY_W-1:0] busy_d;
	tag_t front_d;

	assign tick.ready = !out_valid_q || result.ready;
	assign fire = tick.valid && tick.ready;
	assign clear = (tick.cmd == CMD_CLEAR);
	assign tag_in = tick.event_tag[STORE_W-1:0];

	always_comb begin
		push = 1'b0;
		drop = 1'b0;
		if (!clear && tick.trigger) begin
			push = (count_q < CntDepth);
			drop = !push;
		end
		cnt_pushed = count_q + CNT_W'(push);
		// The front entry leaves on the tick after its done flag.
		pop = !clear && (cnt_pushed != '0) && (xing_q == XingDone);
		wr_pos = pop ? count_q - CNT_W'(1) : count_q;
		xing_inc = xing_q + XING_W'(1);

		count_d = cnt_pushed;
		xing_d = xing_q;
		done_d = done_q;
		if (clear) begin
			count_d = '0;
			xing_d = '0;
			done_d = 1'b0;
		end else if (cnt_pushed == '0) begin
			xing_d = '0;
		end else begin
			done_d = (xing_inc == XingDone);
			if (pop) begin
				count_d = cnt_pushed - CNT_W'(1);
				xing_d = '0;
			end else begin
				xing_d = xing_inc;
			end
		end

		if (clear || count_d == '0) begin
			busy_d = '0;
		end else if (busy_q == '1) begin
			busy_d = busy_q;
		end else begin
			busy_d = busy_q + BUSY_W'(1);
		end

		// No pop coincides with a done tick, so on such a tick the front is cell 0 unless
		// a push goes into an empty queue.
		front_d = (push && count_q == '0) ? tag_in : cell_tag[0];
	end

	for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
		tag_t tag_next;
		if (i == BUFFER_DEPTH - 1) begin : g_last
			assign tag_next = cell_tag[i];
		end else begin : g_mid
			assign tag_next = cell_tag[i+1];
		end
		trb_cell u_cell (
			.clk(clk),
			.load(fire && push && (wr_pos == CNT_W'(i))),
			.shift(fire && pop),
			.tag_new(tag_in),
			.tag_next(tag_next),
			.tag(cell_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xing_q <= '0;
			done_q <= 1'b0;
			busy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
				xing_q <= xing_d;
				done_q <= done_d;
				busy_q <= busy_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_done_q <= done_d;
			out_tag_q <= (done_d && count_d != '0) ? TAG_W'(front_d) : '0;
			out_occ_q <= OCC_W'(count_d);
			out_full_q <= (count_d >= CntDepth);
			out_busy_q <= busy_d;
			out_drop_q <= drop;
		end
	end

	assign result.valid = out_valid_q;
	assign result.event_done = out_done_q;
	assign result.done_tag = out_tag_q;
	assign result.occupancy = out_occ_q;
	assign result.buffer_full = out_full_q;
	assign result.busy_ticks = out_busy_q;
	assign result.trigger_dropped = out_drop_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntDepth)
		else $error("entry count exceeds buffer depth");

	a_done_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> count_q != '0)
		else $error("done flag set with an empty queue");

	a_xing_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		xing_q != '0 |-> count_q != '0)
		else $error("crossing count running with an empty queue");

	a_pop_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop |-> done_q)
		else $error("pop without a preceding done tick");

endmodule

// ----- design/trb_cell.sv -----
// One slot of the tag queue: loads a new tag or takes its neighbor's tag on a pop.
module trb_cell import trb_pkg::*; (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  tag_t tag_new,
	input  tag_t tag_next,
	output tag_t tag
);

	tag_t tag_q;

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q <= tag_new;
		end else if (shift) begin
			tag_q <= tag_next;
		end
	end

	assign tag = tag_q;

endmodule

// ----- tb/tb_trigger_readout_buffer_top.sv -----
// Self-checking testbench for the trigger readout buffer: directed table, then random ticks.
module tb_trigger_readout_buffer_top;
	import trb_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int RANDOM_TICKS = 650;

	typedef struct packed {
		logic event_done;
		logic [TAG_W-1:0] done_tag;
		logic [OCC_W-1:0] occupancy;
		logic buffer_full;
		logic [BUSY_W-1:0] busy_ticks;
		logic trigger_dropped;
	} result_t;

	typedef struct {
		logic cmd;
		logic trigger;
		logic [TAG_W-1:0] event_tag;
		bit known;
		result_t outcome;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	trb_tick_if tick ();
	trb_result_if result ();

	trigger_readout_buffer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted buffer state.
	tag_t fifo_tags [BUFFER_DEPTH];
	int fifo_head;
	int fifo_count;
	int xing_count;
	logic done_state;
	logic [BUSY_W-1:0] busy_run;

	result_t pending_results [$];
	vector_t directed_rows [$];
	int mismatch_count = 0;
	int ticks_sent = 0;
	int idle_cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	function automatic result_t advance_buffer(input logic cmd, input logic trigger,
			input logic [TAG_W-1:0] event_tag);
		result_t r;
		logic dropped;
		dropped = 1'b0;
		if (cmd == CMD_CLEAR) begin
			fifo_head = 0;
			fifo_count = 0;
			xing_count = 0;
			done_state = 1'b0;
			busy_run = '0;
		end else begin
			if (trigger) begin
				if (fifo_count < BUFFER_DEPTH) begin
					fifo_tags[(fifo_head + fifo_count) % BUFFER_DEPTH] = tag_t'(event_tag);
					fifo_count++;
				end else begin
					dropped = 1'b1;
				end
			end
			if (fifo_count == 0) begin
				xing_count = 0;
			end else begin
				xing_count++;
				done_state = (xing_count == PACKET_TICKS);
				// The front entry leaves one tick after its done flag.
				if (xing_count == PACKET_TICKS + 1) begin
					fifo_head = (fifo_head + 1) % BUFFER_DEPTH;
					fifo_count--;
					xing_count = 0;
				end
			end
			if (fifo_count > 0) begin
				if (busy_run != '1)
					busy_run++;
			end else begin
				busy_run = '0;
			end
		end
		r.event_done = done_state;
		r.done_tag = (done_state && fifo_count > 0) ? TAG_W'(fifo_tags[fifo_head]) : '0;
		r.occupancy = OCC_W'(fifo_count);
		r.buffer_full = (fifo_count >= BUFFER_DEPTH);
		r.busy_ticks = busy_run;
		r.trigger_dropped = dropped;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
			input logic [TAG_W-1:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		if (got.event_done !== want.event_done)
			report_mismatch("event_done", TAG_W'(got.event_done), TAG_W'(want.event_done));
		if (got.done_tag !== want.done_tag)
			report_mismatch("done_tag", got.done_tag, want.done_tag);
		if (got.occupancy !== want.occupancy)
			report_mismatch("occupancy", TAG_W'(got.occupancy), TAG_W'(want.occupancy));
		if (got.buffer_full !== want.buffer_full)
			report_mismatch("buffer_full", TAG_W'(got.buffer_full), TAG_W'(want.buffer_full));
		if (got.busy_ticks !== want.busy_ticks)
			report_mismatch("busy_ticks", got.busy_ticks, want.busy_ticks);
		if (got.trigger_dropped !== want.trigger_dropped)
			report_mismatch("trigger_dropped", TAG_W'(got.trigger_dropped),
				TAG_W'(want.trigger_dropped));
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_tick(input vector_t v);
		int gap;
		result_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			tick.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick.valid <= 1'b1;
		tick.cmd <= v.cmd;
		tick.trigger <= v.trigger;
		tick.event_tag <= v.event_tag;
		@(posedge clk);
		while (!tick.ready)
			@(posedge clk);
		predicted = advance_buffer(v.cmd, v.trigger, v.event_tag);
		pending_results.push_back(v.known ? v.outcome : predicted);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		tick.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(input logic cmd, input logic trigger, input logic [TAG_W-1:0] tag,
			input bit known, input result_t outcome);
		vector_t v;
		v.cmd = cmd;
		v.trigger = trigger;
		v.event_tag = tag;
		v.known = known;
		v.outcome = outcome;
		directed_rows.push_back(v);
	endtask

	initial begin : tick_source
		vector_t v;
		int seg_left;
		int trig_pct;
		result_t zero;
		zero = '0;
		tick.valid <= 1'b0;
		tick.cmd <= CMD_TICK;
		tick.trigger <= 1'b0;
		tick.event_tag <= '0;
		fifo_head = 0;
		fifo_count = 0;
		xing_count = 0;
		done_state = 1'b0;
		busy_run = '0;

		// Empty buffer, clear with a trigger, same-tick push at the tag extremes.
		add_row(CMD_TICK, 1'b0, 32'h0000_0000, 1'b1, zero);
		add_row(CMD_CLEAR, 1'b1, 32'hFFFF_FFFF, 1'b1, zero);
		add_row(CMD_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, '0, 6'd1, 1'b0, 32'd1, 1'b0});
		add_row(CMD_TICK, 1'b1, 32'h0000_0000, 1'b1, '{1'b0, '0, 6'd2, 1'b0, 32'd2, 1'b0});
		add_row(CMD_TICK, 1'b0, 32'h1234_5678, 1'b1, '{1'b0, '0, 6'd2, 1'b0, 32'd3, 1'b0});
		add_row(CMD_CLEAR, 1'b0, 32'h0000_0000, 1'b1, zero);
		add_row(CMD_TICK, 1'b0, 32'hFFFF_FFFF, 1'b1, zero);
		add_row(CMD_TICK, 1'b1, 32'hA5A5_5A5A, 1'b1, '{1'b0, '0, 6'd1, 1'b0, 32'd1, 1'b0});
		add_row(CMD_CLEAR, 1'b1, 32'h0000_0000, 1'b1, zero);
		add_row(CMD_TICK, 1'b1, 32'h8000_0000, 1'b0, zero);
		add_row(CMD_TICK, 1'b1, 32'h0000_0001, 1'b0, zero);
		add_row(CMD_TICK, 1'b1, 32'h7FFF_FFFF, 1'b0, zero);
		add_row(CMD_TICK, 1'b1, 32'h5A5A_A5A5, 1'b0, zero);
		add_row(CMD_TICK, 1'b0, 32'hFFFF_FFFF, 1'b0, zero);
		add_row(CMD_TICK, 1'b0, 32'h0000_0000, 1'b0, zero);
		add_row(CMD_TICK, 1'b1, 32'hFFFF_0000, 1'b0, zero);
		add_row(CMD_TICK, 1'b1, 32'h0000_FFFF, 1'b0, zero);

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed_rows[i])
			send_tick(directed_rows[i]);

		// Random bursts: fill past full, drain to empty, occasional clears.
		seg_left = 0;
		trig_pct = 0;
		while (ticks_sent < RANDOM_TICKS) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 90);
				case ($urandom_range(0, 4))
					0: trig_pct = 0;
					1: trig_pct = 5;
					2: trig_pct = 30;
					3: trig_pct = 70;
					default: trig_pct = 100;
				endcase
				tx_burst = ($urandom_range(0, 3) == 0);
			end
			seg_left--;
			if (ticks_sent == 300)
				wait_for_results();
			v.cmd = ($urandom_range(0, 199) == 0) ? CMD_CLEAR : CMD_TICK;
			v.trigger = ($urandom_range(0, 99) < trig_pct);
			if ($urandom_range(0, 9) == 0)
				v.event_tag = {TAG_W{($urandom_range(0, 1) == 1)}};
			else
				v.event_tag = $urandom;
			v.known = 1'b0;
			v.outcome = zero;
			send_tick(v);
		end

		tick.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : result_sink
		int stall;
		result_t got;
		result.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid)
				@(posedge clk);
			got.event_done = result.event_done;
			got.done_tag = result.done_tag;
			got.occupancy = result.occupancy;
			got.buffer_full = result.buffer_full;
			got.busy_ticks = result.busy_ticks;
			got.trigger_dropped = result.trigger_dropped;
			if (pending_results.size() == 0)
				report_mismatch("result with nothing pending, done_tag", got.done_tag, '0);
			else
				compare_result(got, pending_results.pop_front());
			@(negedge clk);
		end
	end

	initial begin : reset_gen
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Ends the run if neither channel completes a transaction for too long.
	always @(posedge clk) begin
		if ((tick.valid && tick.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a transaction", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
